// ===== rtl/lps_pkg.sv =====
// package: sizes, command and state codes, letter conversion table for the light pattern sequencer
package lps_pkg;

  localparam int STYLES      = 32;
  localparam int SLOTS       = 64;
  localparam int STYLE_W     = 5;
  localparam int SLOT_W      = 6;
  localparam int ADDR_W      = STYLE_W + SLOT_W;
  localparam int DEPTH       = STYLES * SLOTS;
  localparam int RGB_W       = 24;
  localparam int LEN_W       = 6;
  localparam int TIME_W      = 31;
  localparam int DIG_BITS    = 4;
  localparam int DIG_N       = 8;
  localparam int DIG_W       = 3;
  localparam int WORK_W      = DIG_BITS * DIG_N;
  localparam int TICK_MS     = 50;
  localparam int MAX_OUT     = 32;
  localparam int OUT_COUNT   = (STYLES < MAX_OUT) ? STYLES : MAX_OUT;

  localparam logic [7:0]         LETTER_A  = 8'h61;
  localparam logic [7:0]         LETTER_Z  = 8'h7a;
  localparam logic [LEN_W-1:0]   TICK_DIV  = LEN_W'(TICK_MS);
  localparam logic [LEN_W-1:0]   LEN_MAX   = LEN_W'(SLOTS - 1);
  localparam logic [STYLE_W-1:0] LAST_STY  = STYLE_W'(OUT_COUNT - 1);
  localparam logic [ADDR_W-1:0]  LAST_ADDR = ADDR_W'(DEPTH - 1);
  localparam logic [DIG_W-1:0]   TOP_DIG   = DIG_W'(DIG_N - 1);

  typedef enum logic [1:0] {
    CMD_WRITE  = 2'd0,
    CMD_LENGTH = 2'd1,
    CMD_TICK   = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WR_READ,
    ST_WR_WRITE,
    ST_DIV,
    ST_LEN,
    ST_MOD,
    ST_READ,
    ST_EMIT
  } state_t;

  function automatic logic [7:0] letter_level(input logic [7:0] letter);
    logic [4:0] k;
    logic [7:0] lvl;
    if (letter < LETTER_A) begin
      k = 5'd0;
    end else if (letter > LETTER_Z) begin
      k = 5'd25;
    end else begin
      k = 5'(letter - LETTER_A);
    end
    unique case (k)
      5'd0:    lvl = 8'd0;
      5'd1:    lvl = 8'd10;
      5'd2:    lvl = 8'd20;
      5'd3:    lvl = 8'd30;
      5'd4:    lvl = 8'd40;
      5'd5:    lvl = 8'd51;
      5'd6:    lvl = 8'd61;
      5'd7:    lvl = 8'd71;
      5'd8:    lvl = 8'd81;
      5'd9:    lvl = 8'd91;
      5'd10:   lvl = 8'd102;
      5'd11:   lvl = 8'd112;
      5'd12:   lvl = 8'd122;
      5'd13:   lvl = 8'd132;
      5'd14:   lvl = 8'd142;
      5'd15:   lvl = 8'd153;
      5'd16:   lvl = 8'd163;
      5'd17:   lvl = 8'd173;
      5'd18:   lvl = 8'd183;
      5'd19:   lvl = 8'd193;
      5'd20:   lvl = 8'd204;
      5'd21:   lvl = 8'd214;
      5'd22:   lvl = 8'd224;
      5'd23:   lvl = 8'd234;
      5'd24:   lvl = 8'd244;
      default: lvl = 8'd255;
    endcase
    return lvl;
  endfunction

endpackage

// ===== rtl/lps_ram.sv =====
// generic single write port ram with registered read
module lps_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/lps_divstep.sv =====
// shared remainder unit: four restoring division steps on a narrow divisor
module lps_divstep (
  input  logic [lps_pkg::LEN_W-1:0]    rem_in,
  input  logic [lps_pkg::DIG_BITS-1:0] digit,
  input  logic [lps_pkg::LEN_W-1:0]    divisor,
  output logic [lps_pkg::LEN_W-1:0]    rem_out,
  output logic [lps_pkg::DIG_BITS-1:0] quot
);
  import lps_pkg::*;

  logic [LEN_W-1:0] r;
  logic [LEN_W:0]   t;

  always_comb begin
    r    = rem_in;
    t    = '0;
    quot = '0;
    for (int i = DIG_BITS - 1; i >= 0; i--) begin
      t = {r, digit[i]};
      if (t >= {1'b0, divisor}) begin
        r       = LEN_W'(t - {1'b0, divisor});
        quot[i] = 1'b1;
      end else begin
        r = t[LEN_W-1:0];
      end
    end
    rem_out = r;
  end

endmodule

// ===== rtl/light_pattern_sequencer.sv =====
// top level: light pattern sequencer with pattern ram and shared remainder unit
//
//  channel   ports                                    handshake
//  command   in_command .. in_time_ms                 start, busy
//  result    out_style, out_red/green/blue, out_last  out_valid, one cycle
//
//  letter write: read-modify-write of the pattern ram, length: written while staying idle
//  clear and reset: pass zeroing all 2048 pattern ram entries, busy high throughout
//  tick: time/50 over 8 digits in the 4-bit remainder unit, then per style
//  either an all-ones result (length zero) or 8 remainder digits, ram read, result
//  results cannot be stalled; busy stays high until the last transfer is issued
module light_pattern_sequencer (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   in_command,
  input  logic [lps_pkg::STYLE_W-1:0]  in_style,
  input  logic [1:0]                   in_channel,
  input  logic [lps_pkg::SLOT_W-1:0]   in_position,
  input  logic [7:0]                   in_letter,
  input  logic [lps_pkg::LEN_W-1:0]    in_pattern_length,
  input  logic [lps_pkg::TIME_W-1:0]   in_time_ms,
  output logic                         out_valid,
  output logic [lps_pkg::STYLE_W-1:0]  out_style,
  output logic [7:0]                   out_red,
  output logic [7:0]                   out_green,
  output logic [7:0]                   out_blue,
  output logic                         out_last
);
  import lps_pkg::*;

  state_t               state_r, state_nxt;
  logic [LEN_W-1:0]     len_r [STYLES];
  logic [LEN_W-1:0]     len_wval;
  logic                 len_we;
  logic                 len_clr;
  logic [ADDR_W-1:0]    clr_cnt_r, clr_cnt_nxt;
  logic [ADDR_W-1:0]    waddr_r, waddr_nxt;
  logic [1:0]           chan_r, chan_nxt;
  logic [7:0]           level_r, level_nxt;
  logic [WORK_W-1:0]    time_r, time_nxt;
  logic [WORK_W-1:0]    ofs_r, ofs_nxt;
  logic [LEN_W-1:0]     rem_r, rem_nxt;
  logic [DIG_W-1:0]     dig_r, dig_nxt;
  logic [STYLE_W-1:0]   sty_r, sty_nxt;
  logic                 oval_r, oval_nxt;
  logic [STYLE_W-1:0]   osty_r, osty_nxt;
  logic [RGB_W-1:0]     orgb_r, orgb_nxt;
  logic                 olast_r, olast_nxt;

  logic                 ram_we;
  logic [ADDR_W-1:0]    ram_waddr;
  logic [RGB_W-1:0]     ram_wdata;
  logic [ADDR_W-1:0]    ram_raddr;
  logic [RGB_W-1:0]     ram_rdata;

  logic [DIG_BITS-1:0]  du_digit;
  logic [LEN_W-1:0]     du_div;
  logic [LEN_W-1:0]     du_rem;
  logic [DIG_BITS-1:0]  du_quot;
  logic [LEN_W-1:0]     cur_len;
  logic [DIG_W+1:0]     dig_idx;

  lps_ram #(.WIDTH(RGB_W), .DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  lps_divstep u_div (
    .rem_in  (rem_r),
    .digit   (du_digit),
    .divisor (du_div),
    .rem_out (du_rem),
    .quot    (du_quot)
  );

  assign cur_len = len_r[sty_r];
  assign dig_idx = {dig_r, 2'b00};
  assign du_digit = (state_r == ST_DIV) ? time_r[dig_idx +: DIG_BITS]
                                        : ofs_r[dig_idx +: DIG_BITS];
  assign du_div   = (state_r == ST_DIV) ? TICK_DIV : cur_len;
  assign ram_raddr = (state_r == ST_READ) ? {sty_r, rem_r} : waddr_r;

  always_comb begin
    state_nxt   = state_r;
    clr_cnt_nxt = clr_cnt_r;
    waddr_nxt   = waddr_r;
    chan_nxt    = chan_r;
    level_nxt   = level_r;
    time_nxt    = time_r;
    ofs_nxt     = ofs_r;
    rem_nxt     = rem_r;
    dig_nxt     = dig_r;
    sty_nxt     = sty_r;
    oval_nxt    = 1'b0;
    osty_nxt    = osty_r;
    orgb_nxt    = orgb_r;
    olast_nxt   = olast_r;
    len_we      = 1'b0;
    len_clr     = 1'b0;
    len_wval    = (in_pattern_length > LEN_MAX) ? LEN_MAX : in_pattern_length;
    ram_we      = 1'b0;
    ram_waddr   = waddr_r;
    ram_wdata   = ram_rdata;
    unique case (state_r)
      ST_CLEAR: begin
        ram_we      = 1'b1;
        ram_waddr   = clr_cnt_r;
        ram_wdata   = '0;
        clr_cnt_nxt = ADDR_W'(clr_cnt_r + 1'b1);
        if (clr_cnt_r == LAST_ADDR) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          unique case (in_command)
            CMD_WRITE: begin
              waddr_nxt = {in_style, in_position};
              chan_nxt  = in_channel;
              level_nxt = letter_level(in_letter);
              if (({1'b0, in_style} < (STYLE_W + 1)'(STYLES)) && (in_channel != 2'd3) &&
                  ({1'b0, in_position} < (SLOT_W + 1)'(SLOTS))) begin
                state_nxt = ST_WR_READ;
              end
            end
            CMD_LENGTH: begin
              len_we = ({1'b0, in_style} < (STYLE_W + 1)'(STYLES));
            end
            CMD_TICK: begin
              time_nxt  = WORK_W'(in_time_ms);
              ofs_nxt   = '0;
              rem_nxt   = '0;
              dig_nxt   = TOP_DIG;
              state_nxt = ST_DIV;
            end
            default: begin
              len_clr     = 1'b1;
              clr_cnt_nxt = '0;
              state_nxt   = ST_CLEAR;
            end
          endcase
        end
      end
      ST_WR_READ: begin
        state_nxt = ST_WR_WRITE;
      end
      ST_WR_WRITE: begin
        ram_we = 1'b1;
        unique case (chan_r)
          2'd0:    ram_wdata[7:0]   = level_r;
          2'd1:    ram_wdata[15:8]  = level_r;
          default: ram_wdata[23:16] = level_r;
        endcase
        state_nxt = ST_IDLE;
      end
      ST_DIV: begin
        rem_nxt = du_rem;
        ofs_nxt = {ofs_r[WORK_W-DIG_BITS-1:0], du_quot};
        dig_nxt = DIG_W'(dig_r - 1'b1);
        if (dig_r == '0) begin
          sty_nxt   = '0;
          state_nxt = ST_LEN;
        end
      end
      ST_LEN: begin
        if (cur_len == '0) begin
          oval_nxt  = 1'b1;
          osty_nxt  = sty_r;
          orgb_nxt  = '1;
          olast_nxt = (sty_r == LAST_STY);
          sty_nxt   = STYLE_W'(sty_r + 1'b1);
          if (sty_r == LAST_STY) begin
            state_nxt = ST_IDLE;
          end
        end else begin
          rem_nxt   = '0;
          dig_nxt   = TOP_DIG;
          state_nxt = ST_MOD;
        end
      end
      ST_MOD: begin
        rem_nxt = du_rem;
        dig_nxt = DIG_W'(dig_r - 1'b1);
        if (dig_r == '0) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        oval_nxt  = 1'b1;
        osty_nxt  = sty_r;
        orgb_nxt  = ram_rdata;
        olast_nxt = (sty_r == LAST_STY);
        sty_nxt   = STYLE_W'(sty_r + 1'b1);
        state_nxt = (sty_r == LAST_STY) ? ST_IDLE : ST_LEN;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      clr_cnt_r <= '0;
      oval_r    <= 1'b0;
      for (int i = 0; i < STYLES; i++) begin
        len_r[i] <= '0;
      end
    end else begin
      state_r   <= state_nxt;
      clr_cnt_r <= clr_cnt_nxt;
      oval_r    <= oval_nxt;
      if (len_clr) begin
        for (int i = 0; i < STYLES; i++) begin
          len_r[i] <= '0;
        end
      end else if (len_we) begin
        len_r[in_style] <= len_wval;
      end
    end
  end

  always_ff @(posedge clk) begin
    waddr_r <= waddr_nxt;
    chan_r  <= chan_nxt;
    level_r <= level_nxt;
    time_r  <= time_nxt;
    ofs_r   <= ofs_nxt;
    rem_r   <= rem_nxt;
    dig_r   <= dig_nxt;
    sty_r   <= sty_nxt;
    osty_r  <= osty_nxt;
    orgb_r  <= orgb_nxt;
    olast_r <= olast_nxt;
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = oval_r;
  assign out_style = osty_r;
  assign out_red   = orgb_r[7:0];
  assign out_green = orgb_r[15:8];
  assign out_blue  = orgb_r[23:16];
  assign out_last  = olast_r;

endmodule

// ===== rtl/lps_checker.sv =====
// port level checks for the light pattern sequencer, bound to the top level
module lps_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        start,
  input logic                        busy,
  input logic [1:0]                  in_command,
  input logic                        out_valid,
  input logic [lps_pkg::STYLE_W-1:0] out_style,
  input logic                        out_last
);
  import lps_pkg::*;

  // clearing pass follows reset
  a_busy_after_reset: assert property (@(posedge clk) !rst_n |=> busy)
    else $error("not busy after reset");

  // a tick stays busy until its final transfer
  a_busy_mid_tick: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> busy)
    else $error("idle before final transfer of a tick");

  // final transfer carries the last style
  a_last_style: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> out_style == LAST_STY)
    else $error("last flag on wrong style");

  // only ticks produce transfers
  a_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && (in_command != CMD_TICK) |=> !out_valid)
    else $error("transfer after non-tick command");

endmodule

bind light_pattern_sequencer lps_checker u_lps_checker (.*);

// ===== sim/testbench.sv =====
// testbench for the light pattern sequencer: directed table and random commands, scoreboard check
module testbench;
  import lps_pkg::*;

  localparam int RAND_ITEMS = 310;
  localparam int CALM_TAIL  = 40;
  localparam int PRINT_CAP  = 100;

  typedef struct packed {
    cmd_t        cmd;
    logic [4:0]  style;
    logic [1:0]  channel;
    logic [5:0]  position;
    logic [7:0]  letter;
    logic [5:0]  plen;
    logic [30:0] tms;
    logic        chk;
    logic [23:0] chk_rgb;
  } cmd_item_t;

  typedef struct packed {
    logic [4:0] style;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last;
  } color_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  in_command = CMD_WRITE;
  logic [4:0]  in_style = '0;
  logic [1:0]  in_channel = '0;
  logic [5:0]  in_position = '0;
  logic [7:0]  in_letter = '0;
  logic [5:0]  in_pattern_length = '0;
  logic [30:0] in_time_ms = '0;
  logic        out_valid;
  logic [4:0]  out_style;
  logic [7:0]  out_red;
  logic [7:0]  out_green;
  logic [7:0]  out_blue;
  logic        out_last;

  light_pattern_sequencer dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_command        (in_command),
    .in_style          (in_style),
    .in_channel        (in_channel),
    .in_position       (in_position),
    .in_letter         (in_letter),
    .in_pattern_length (in_pattern_length),
    .in_time_ms        (in_time_ms),
    .out_valid         (out_valid),
    .out_style         (out_style),
    .out_red           (out_red),
    .out_green         (out_green),
    .out_blue          (out_blue),
    .out_last          (out_last)
  );

  always #6 clk = ~clk;

  logic [5:0]  len_mem [STYLES];
  logic [23:0] rgb_mem [DEPTH];
  color_t      color_q [$];
  cmd_item_t   dir_rows [$];
  int          err_cnt = 0;

  task automatic flag(input string what, input int got, input int want);
    if (err_cnt < PRINT_CAP) begin
      $display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
    end
    err_cnt++;
  endtask

  function automatic logic [7:0] letter_intensity(input logic [7:0] ch);
    int k;
    if (ch < LETTER_A) begin
      k = 0;
    end else if (ch > LETTER_Z) begin
      k = 25;
    end else begin
      k = int'(ch - LETTER_A);
    end
    return 8'((k * 255) / 25);
  endfunction

  task automatic clear_patterns();
    foreach (len_mem[i]) len_mem[i] = '0;
    foreach (rgb_mem[i]) rgb_mem[i] = '0;
  endtask

  task automatic predict_colors(input cmd_item_t it);
    int unsigned ofs;
    logic [5:0]  stp;
    logic [23:0] rgb;
    color_t      c;
    case (it.cmd)
      CMD_WRITE: begin
        if (it.channel != 2'd3) begin
          rgb_mem[{it.style, it.position}][8*it.channel +: 8] = letter_intensity(it.letter);
        end
      end
      CMD_LENGTH: begin
        len_mem[it.style] = (it.plen > LEN_MAX) ? LEN_MAX : it.plen;
      end
      CMD_CLEAR: begin
        clear_patterns();
      end
      default: begin
        ofs = it.tms / 50;
        for (int s = 0; s < OUT_COUNT; s++) begin
          if (len_mem[s] == 0) begin
            rgb = 24'hFFFFFF;
          end else begin
            stp = 6'(ofs % len_mem[s]);
            rgb = rgb_mem[{5'(s), stp}];
          end
          if (it.chk && it.style == 5'(s)) rgb = it.chk_rgb;
          c.style = 5'(s);
          c.red   = rgb[7:0];
          c.green = rgb[15:8];
          c.blue  = rgb[23:16];
          c.last  = (s == OUT_COUNT - 1);
          color_q.push_back(c);
        end
      end
    endcase
  endtask

  always @(posedge clk) begin
    color_t want;
    if (rst_n && out_valid) begin
      if (color_q.size() == 0) begin
        flag("unexpected transfer, style", out_style, -1);
      end else begin
        want = color_q.pop_front();
        if (out_style != want.style) flag("style", out_style, want.style);
        if (out_red   != want.red)   flag("red",   out_red,   want.red);
        if (out_green != want.green) flag("green", out_green, want.green);
        if (out_blue  != want.blue)  flag("blue",  out_blue,  want.blue);
        if (out_last  != want.last)  flag("last",  out_last,  want.last);
      end
    end
  end

  function automatic cmd_item_t mk_row(input cmd_t c, input logic [4:0] sty,
                                       input logic [1:0] ch, input logic [5:0] pos,
                                       input logic [7:0] ltr, input logic [5:0] plen,
                                       input logic [30:0] tms, input logic chk,
                                       input logic [23:0] rgb);
    cmd_item_t r;
    r.cmd = c; r.style = sty; r.channel = ch; r.position = pos; r.letter = ltr;
    r.plen = plen; r.tms = tms; r.chk = chk; r.chk_rgb = rgb;
    return r;
  endfunction

  function automatic cmd_item_t rand_item();
    cmd_item_t r;
    int        p;
    p = $urandom_range(0, 99);
    if (p < 55)      r.cmd = CMD_WRITE;
    else if (p < 70) r.cmd = CMD_LENGTH;
    else if (p < 97) r.cmd = CMD_TICK;
    else             r.cmd = CMD_CLEAR;
    r.style    = 5'($urandom);
    r.channel  = ($urandom_range(0, 15) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
    r.position = ($urandom_range(0, 4) == 0) ? 6'($urandom) : 6'($urandom_range(0, 7));
    r.letter   = ($urandom_range(0, 3) == 0) ? 8'($urandom)
                                             : 8'($urandom_range(LETTER_A, LETTER_Z));
    p = $urandom_range(0, 9);
    if (p == 0)      r.plen = '0;
    else if (p == 1) r.plen = 6'($urandom);
    else             r.plen = 6'($urandom_range(1, 8));
    r.tms = ($urandom_range(0, 3) == 0) ? 31'($urandom) : 31'($urandom_range(0, 5000));
    r.chk = 1'b0;
    r.chk_rgb = '0;
    return r;
  endfunction

  task automatic issue(input cmd_item_t it, input bit may_idle);
    if (may_idle && $urandom_range(0, 2) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_command        <= it.cmd;
    in_style          <= it.style;
    in_channel        <= it.channel;
    in_position       <= it.position;
    in_letter         <= it.letter;
    in_pattern_length <= it.plen;
    in_time_ms        <= it.tms;
    start             <= 1'b1;
    do @(posedge clk); while (busy);
    predict_colors(it);
  endtask

  initial begin
    cmd_item_t it;
    int        sent;
    bit        quiet;
    clear_patterns();
    dir_rows.push_back(mk_row(CMD_TICK,   5'd0,  2'd0, 6'd0,  8'h00, 6'd0,  31'd0,  1, 24'hFFFFFF));
    dir_rows.push_back(mk_row(CMD_LENGTH, 5'd0,  2'd0, 6'd0,  8'h00, 6'd1,  31'd0,  0, 24'h0));
    dir_rows.push_back(mk_row(CMD_WRITE,  5'd0,  2'd0, 6'd0,  8'h7a, 6'd0,  31'd0,  0, 24'h0));
    dir_rows.push_back(mk_row(CMD_WRITE,  5'd0,  2'd1, 6'd0,  8'h00, 6'd0,  31'd0,  0, 24'h0));
    dir_rows.push_back(mk_row(CMD_WRITE,  5'd0,  2'd2, 6'd0,  8'hff, 6'd0,  31'd0,  0, 24'h0));
    dir_rows.push_back(mk_row(CMD_TICK,   5'd0,  2'd3, 6'd63, 8'hff, 6'd63,
                              31'h7fffffff, 1, 24'hFF00FF));
    dir_rows.push_back(mk_row(CMD_WRITE,  5'd31, 2'd0, 6'd62, 8'h61, 6'd0,  31'd0,  0, 24'h0));
    dir_rows.push_back(mk_row(CMD_WRITE,  5'd31, 2'd1, 6'd62, 8'h6d, 6'd0,  31'd0,  0, 24'h0));
    dir_rows.push_back(mk_row(CMD_WRITE,  5'd31, 2'd3, 6'd62, 8'h7a, 6'd0,  31'd0,  0, 24'h0));
    dir_rows.push_back(mk_row(CMD_LENGTH, 5'd31, 2'd0, 6'd0,  8'h00, 6'd63, 31'd0,  0, 24'h0));
    dir_rows.push_back(mk_row(CMD_WRITE,  5'd31, 2'd2, 6'd63, 8'h62, 6'd0,  31'd0,  0, 24'h0));
    dir_rows.push_back(mk_row(CMD_TICK,   5'd31, 2'd0, 6'd0,  8'h00, 6'd0,  31'd3100, 1, 24'h007A00));
    dir_rows.push_back(mk_row(CMD_TICK,   5'd31, 2'd0, 6'd0,  8'h00, 6'd0,  31'd3150, 1, 24'h000000));
    dir_rows.push_back(mk_row(CMD_LENGTH, 5'd3,  2'd0, 6'd0,  8'h00, 6'd2,  31'd0,  0, 24'h0));
    dir_rows.push_back(mk_row(CMD_WRITE,  5'd3,  2'd0, 6'd1,  8'h79, 6'd0,  31'd0,  0, 24'h0));
    dir_rows.push_back(mk_row(CMD_WRITE,  5'd3,  2'd1, 6'd0,  8'h70, 6'd0,  31'd0,  0, 24'h0));
    dir_rows.push_back(mk_row(CMD_TICK,   5'd3,  2'd0, 6'd0,  8'h00, 6'd0,  31'd99, 1, 24'h0000F4));
    dir_rows.push_back(mk_row(CMD_CLEAR,  5'd31, 2'd3, 6'd63, 8'hff, 6'd63,
                              31'h7fffffff, 0, 24'h0));
    dir_rows.push_back(mk_row(CMD_TICK,   5'd31, 2'd0, 6'd0,  8'h00, 6'd0,  31'd3100, 1, 24'hFFFFFF));
    dir_rows.push_back(mk_row(CMD_WRITE,  5'd0,  2'd0, 6'd0,  8'h7a, 6'd0,  31'd0,  0, 24'h0));
    dir_rows.push_back(mk_row(CMD_LENGTH, 5'd0,  2'd0, 6'd0,  8'h00, 6'd0,  31'd0,  0, 24'h0));
    dir_rows.push_back(mk_row(CMD_TICK,   5'd0,  2'd0, 6'd0,  8'h00, 6'd0,  31'd1234, 1, 24'hFFFFFF));

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) issue(dir_rows[i], 1'b1);

    sent = 0;
    quiet = 1'b0;
    while (sent < RAND_ITEMS) begin
      if (sent % 16 == 0) quiet = ($urandom_range(0, 3) == 0);
      it = rand_item();
      issue(it, !quiet && sent < RAND_ITEMS - CALM_TAIL);
      if (!(it.cmd == CMD_WRITE && it.channel == 2'd3)) sent++;
    end
    start <= 1'b0;

    while (color_q.size() != 0) @(posedge clk);
    while (busy) @(posedge clk);
    repeat (16) @(posedge clk);
    if (err_cnt == 0) begin
      $display("PASS light_pattern_sequencer");
    end else begin
      $display("FAIL light_pattern_sequencer");
    end
    $finish;
  end

  initial begin
    #(12 * 1500000);
    $display("FAIL light_pattern_sequencer");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/lps_pkg.sv
rtl/lps_ram.sv
rtl/lps_divstep.sv
rtl/light_pattern_sequencer.sv
rtl/lps_checker.sv
sim/testbench.sv
